FILE: rtl/cds_pkg.sv
`default_nettype none
package cds_pkg;

    // Fixed field widths
    localparam int unsigned CTW = 11;   // chunk_total register
    localparam int unsigned CBW = 25;   // chunk_bytes, byte_count, chunk_length
    localparam int unsigned FBW = 35;   // file_bytes, offsets, byte totals
    localparam int unsigned CLW = 4;    // credit_limit, per-peer credit
    localparam int unsigned IPW = 5;    // initial_peers register
    localparam int unsigned ATW = 6;    // attempt counter
    localparam int unsigned STW = 3;    // status
    localparam int unsigned CFG_IW = 3; // config index
    localparam int unsigned CFG_DW = 35;

    localparam logic [ATW-1:0] ATT_MAX   = 6'd63;
    localparam logic [ATW-1:0] ATT_FLOOR = 6'd3;

    // Config register indexes
    localparam logic [CFG_IW-1:0] CFG_CHUNK_TOTAL   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_CHUNK_BYTES   = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_FILE_BYTES    = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_CREDIT_LIMIT  = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_INITIAL_PEERS = 3'd4;

    // Functions of an input item
    localparam logic [1:0] FN_START    = 2'd0;
    localparam logic [1:0] FN_DISPATCH = 2'd1;
    localparam logic [1:0] FN_REPORT   = 2'd2;
    localparam logic [1:0] FN_ADD_PEER = 2'd3;

    // Report outcomes
    localparam logic [1:0] OC_OK          = 2'd0;
    localparam logic [1:0] OC_WRITE_FAIL  = 2'd3;

    // Result status codes
    localparam logic [STW-1:0] ST_NONE     = 3'd0;
    localparam logic [STW-1:0] ST_GRANTED  = 3'd1;
    localparam logic [STW-1:0] ST_REQUEUED = 3'd2;
    localparam logic [STW-1:0] ST_ACCEPTED = 3'd3;
    localparam logic [STW-1:0] ST_FINISHED = 3'd4;
    localparam logic [STW-1:0] ST_FAILED   = 3'd5;
    localparam logic [STW-1:0] ST_PEER     = 3'd6;

    typedef enum logic [1:0] {
        H_RUN,
        H_FINISHED,
        H_FAILED
    } t_halt;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_SCAN,
        S_FETCH,
        S_CLIP,
        S_CHECK,
        S_APPLY,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

FILE: rtl/cds_ram.sv
`default_nettype none
module cds_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire                                        i_clk,
    input  wire                                        i_we,
    input  wire  [((DEPTH>1)?$clog2(DEPTH):1)-1:0]     i_waddr,
    input  wire  [WIDTH-1:0]                           i_wdata,
    input  wire  [((DEPTH>1)?$clog2(DEPTH):1)-1:0]     i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/chunk_dispatch_scheduler.sv
`default_nettype none
// Channel   Direction  Handshake                     Payload
// in        input      i_in_valid / o_in_ready       i_func i_chunk_sel i_peer_sel
//                                                    i_outcome i_byte_count
// out       output     o_out_valid / i_out_ready     o_status o_chunk_out o_peer_out
//                                                    o_chunk_offset o_chunk_length
//                                                    o_done_count o_active_peers o_bytes_done
// cfg       input      i_cfg_we (no wait)            i_cfg_idx i_cfg_data
//
// One item at a time. Add peer: straight to the output state. Report: check, then
// apply when the report passes (chunk state read-modify-write in RAM), then output.
// Dispatch: round-robin scan, FIFO read, offset multiply, clip, then output.
// Start: a sweep over all MAX_CHUNKS entries that refills the job FIFO and clears
// the chunk state RAM one entry a cycle. Reset needs no sweep.
// A pending result in the output register stalls only the next result.
module chunk_dispatch_scheduler #(
    parameter int unsigned MAX_CHUNKS = 1024,
    parameter int unsigned MAX_PEERS  = 16
) (
    input  wire                                           i_clk,
    input  wire                                           i_rst_n,
    input  wire                                           i_cfg_we,
    input  wire  [cds_pkg::CFG_IW-1:0]                    i_cfg_idx,
    input  wire  [cds_pkg::CFG_DW-1:0]                    i_cfg_data,
    input  wire                                           i_in_valid,
    output logic                                          o_in_ready,
    input  wire  [1:0]                                    i_func,
    input  wire  [((MAX_CHUNKS>1)?$clog2(MAX_CHUNKS):1)-1:0] i_chunk_sel,
    input  wire  [((MAX_PEERS>1)?$clog2(MAX_PEERS):1)-1:0]   i_peer_sel,
    input  wire  [1:0]                                    i_outcome,
    input  wire  [cds_pkg::CBW-1:0]                       i_byte_count,
    output logic                                          o_out_valid,
    input  wire                                           i_out_ready,
    output logic [cds_pkg::STW-1:0]                       o_status,
    output logic [((MAX_CHUNKS>1)?$clog2(MAX_CHUNKS):1)-1:0] o_chunk_out,
    output logic [((MAX_PEERS>1)?$clog2(MAX_PEERS):1)-1:0]   o_peer_out,
    output logic [cds_pkg::FBW-1:0]                       o_chunk_offset,
    output logic [cds_pkg::CBW-1:0]                       o_chunk_length,
    output logic [$clog2(MAX_CHUNKS+1)-1:0]               o_done_count,
    output logic [$clog2(MAX_PEERS+1)-1:0]                o_active_peers,
    output logic [cds_pkg::FBW-1:0]                       o_bytes_done
);
    localparam int unsigned CIW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int unsigned CCW = $clog2(MAX_CHUNKS + 1);
    localparam int unsigned PIW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int unsigned PCW = $clog2(MAX_PEERS + 1);
    localparam int unsigned PW  = CIW + cds_pkg::CBW;
    localparam int unsigned OW  = (PW > cds_pkg::FBW) ? PW : cds_pkg::FBW;
    localparam int unsigned AW  = CIW;
    localparam int unsigned CSW = cds_pkg::ATW + 1;

    // Config registers
    logic [cds_pkg::CTW-1:0] r_chunk_total;
    logic [cds_pkg::CBW-1:0] r_chunk_bytes;
    logic [cds_pkg::FBW-1:0] r_file_bytes;
    logic [cds_pkg::CLW-1:0] r_credit_limit;
    logic [cds_pkg::IPW-1:0] r_initial_peers;

    // Run state
    cds_pkg::t_state         r_state, n_state;
    cds_pkg::t_halt          r_halted;
    logic [CCW-1:0]          r_n_chunks;
    logic [PCW-1:0]          r_peer_count;
    logic [CIW-1:0]          r_head;
    logic [CCW-1:0]          r_count;
    logic [PIW-1:0]          r_rr;
    logic [CCW-1:0]          r_completed;
    logic [PCW-1:0]          r_active;
    logic [cds_pkg::FBW-1:0] r_byte_total;
    logic [cds_pkg::CLW-1:0] r_credit [MAX_PEERS];
    logic [MAX_PEERS-1:0]    r_delivered;

    // Item in flight
    logic [CIW-1:0]          r_chunk_sel;
    logic [PIW-1:0]          r_peer_sel;
    logic [1:0]              r_outcome;
    logic [cds_pkg::CBW-1:0] r_byte_count;
    logic [CIW-1:0]          r_sweep;
    logic [PIW-1:0]          r_scan_idx;
    logic [PCW-1:0]          r_scan_n;
    logic [cds_pkg::STW-1:0] r_res_status;
    logic [CIW-1:0]          r_res_chunk;
    logic [PIW-1:0]          r_res_peer;
    logic [OW-1:0]           r_off;
    logic [cds_pkg::CBW-1:0] r_res_len;

    // Output register
    logic                    r_out_valid;
    logic [cds_pkg::STW-1:0] r_o_status;
    logic [CIW-1:0]          r_o_chunk;
    logic [PIW-1:0]          r_o_peer;
    logic [cds_pkg::FBW-1:0] r_o_off;
    logic [cds_pkg::CBW-1:0] r_o_len;
    logic [CCW-1:0]          r_o_done;
    logic [PCW-1:0]          r_o_active;
    logic [cds_pkg::FBW-1:0] r_o_bytes;

    // RAM ports
    logic                    fifo_we;
    logic [AW-1:0]           fifo_waddr, fifo_raddr;
    logic [CIW-1:0]          fifo_wdata, fifo_rdata;
    logic                    cst_we;
    logic [AW-1:0]           cst_waddr, cst_raddr;
    logic [CSW-1:0]          cst_wdata, cst_rdata;

    // Combinational helpers
    logic                    in_fire;
    logic [cds_pkg::CLW-1:0] lim;
    logic                    scan_hit, scan_last;
    logic [PIW-1:0]          scan_next;
    logic [CIW-1:0]          head_next;
    logic [CCW:0]            tail_sum;
    logic [CIW-1:0]          tail;
    logic                    rep_halted, rep_bad, rep_wfail;
    logic                    rep_ok;
    logic                    cs_done;
    logic [cds_pkg::ATW-1:0] cs_att, att_inc;
    logic [PCW:0]            thr_wide;
    logic [cds_pkg::ATW-1:0] thr;
    logic                    att_fatal;
    logic [CCW-1:0]          completed_inc;
    logic [cds_pkg::FBW:0]   byte_sum;
    logic [OW-1:0]           len_wide;
    logic                    out_free;
    logic [CCW-1:0]          n_chunks_clamp;
    logic [PCW-1:0]          peers_clamp;

    cds_ram #(.WIDTH(CIW), .DEPTH(MAX_CHUNKS)) u_job_fifo (
        .i_clk   (i_clk),
        .i_we    (fifo_we),
        .i_waddr (fifo_waddr),
        .i_wdata (fifo_wdata),
        .i_raddr (fifo_raddr),
        .o_rdata (fifo_rdata)
    );

    // Chunk state: {done, attempts}
    cds_ram #(.WIDTH(CSW), .DEPTH(MAX_CHUNKS)) u_chunk_state (
        .i_clk   (i_clk),
        .i_we    (cst_we),
        .i_waddr (cst_waddr),
        .i_wdata (cst_wdata),
        .i_raddr (cst_raddr),
        .o_rdata (cst_rdata)
    );

    assign o_in_ready = (r_state == cds_pkg::S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // Clamp start values
    always_comb begin
        if (r_chunk_total == '0) begin
            n_chunks_clamp = CCW'(1);
        end else if (32'(r_chunk_total) > MAX_CHUNKS) begin
            n_chunks_clamp = CCW'(MAX_CHUNKS);
        end else begin
            n_chunks_clamp = CCW'(r_chunk_total);
        end
        if (r_initial_peers == '0) begin
            peers_clamp = PCW'(1);
        end else if (32'(r_initial_peers) > MAX_PEERS) begin
            peers_clamp = PCW'(MAX_PEERS);
        end else begin
            peers_clamp = PCW'(r_initial_peers);
        end
    end

    // Round-robin scan step
    always_comb begin
        lim       = (r_credit_limit == '0) ? cds_pkg::CLW'(1) : r_credit_limit;
        scan_hit  = r_credit[r_scan_idx] < lim;
        scan_last = (r_scan_n + PCW'(1)) == r_peer_count;
        scan_next = ((PCW'(r_scan_idx) + PCW'(1)) == r_peer_count) ? '0
                                                                 : r_scan_idx + PIW'(1);
        head_next = (32'(r_head) == MAX_CHUNKS - 1) ? '0 : r_head + CIW'(1);
        tail_sum  = (CCW+1)'(r_head) + (CCW+1)'(r_count);
        tail      = (32'(tail_sum) >= MAX_CHUNKS) ? CIW'(tail_sum - (CCW+1)'(MAX_CHUNKS))
                                                  : CIW'(tail_sum);
    end

    // Report decode
    always_comb begin
        rep_halted    = (r_halted != cds_pkg::H_RUN);
        rep_bad       = (CCW'(r_chunk_sel) >= r_n_chunks) ||
                        (PCW'(r_peer_sel) >= r_peer_count);
        rep_wfail     = (r_outcome == cds_pkg::OC_WRITE_FAIL);
        rep_ok        = (r_outcome == cds_pkg::OC_OK) && (r_byte_count != '0);
        cs_done       = cst_rdata[cds_pkg::ATW];
        cs_att        = cst_rdata[cds_pkg::ATW-1:0];
        att_inc       = (cs_att < cds_pkg::ATT_MAX) ? cs_att + cds_pkg::ATW'(1) : cs_att;
        thr_wide      = {r_peer_count, 1'b0};
        if (thr_wide < (PCW+1)'(cds_pkg::ATT_FLOOR)) begin
            thr = cds_pkg::ATT_FLOOR;
        end else if (thr_wide > (PCW+1)'(cds_pkg::ATT_MAX)) begin
            thr = cds_pkg::ATT_MAX;
        end else begin
            thr = cds_pkg::ATW'(thr_wide);
        end
        att_fatal     = att_inc >= thr;
        completed_inc = (!cs_done && (r_completed < r_n_chunks)) ? r_completed + CCW'(1)
                                                                 : r_completed;
        byte_sum      = (cds_pkg::FBW+1)'(r_byte_total) + (cds_pkg::FBW+1)'(r_byte_count);
        len_wide      = OW'(r_file_bytes) - r_off;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cds_pkg::S_IDLE: begin
                if (in_fire) begin
                    case (i_func)
                        cds_pkg::FN_START: n_state = cds_pkg::S_CLEAR;
                        cds_pkg::FN_DISPATCH: begin
                            if (r_halted != cds_pkg::H_RUN || r_count == '0) begin
                                n_state = cds_pkg::S_OUT;
                            end else begin
                                n_state = cds_pkg::S_SCAN;
                            end
                        end
                        cds_pkg::FN_REPORT: n_state = cds_pkg::S_CHECK;
                        default: n_state = cds_pkg::S_OUT;
                    endcase
                end
            end
            cds_pkg::S_CLEAR: begin
                if (32'(r_sweep) == MAX_CHUNKS - 1) n_state = cds_pkg::S_OUT;
            end
            cds_pkg::S_SCAN: begin
                if (scan_hit) begin
                    n_state = cds_pkg::S_FETCH;
                end else if (scan_last) begin
                    n_state = cds_pkg::S_OUT;
                end
            end
            cds_pkg::S_FETCH: n_state = cds_pkg::S_CLIP;
            cds_pkg::S_CLIP:  n_state = cds_pkg::S_OUT;
            cds_pkg::S_CHECK: begin
                if (rep_halted || rep_bad || rep_wfail) begin
                    n_state = cds_pkg::S_OUT;
                end else begin
                    n_state = cds_pkg::S_APPLY;
                end
            end
            cds_pkg::S_APPLY: n_state = cds_pkg::S_OUT;
            cds_pkg::S_OUT: begin
                if (out_free) n_state = cds_pkg::S_IDLE;
            end
            default: n_state = cds_pkg::S_IDLE;
        endcase
    end

    // RAM controls
    always_comb begin
        fifo_we    = 1'b0;
        fifo_waddr = AW'(r_sweep);
        fifo_wdata = r_sweep;
        fifo_raddr = AW'(r_head);
        cst_we     = 1'b0;
        cst_waddr  = AW'(r_chunk_sel);
        cst_wdata  = '0;
        cst_raddr  = AW'(r_chunk_sel);
        case (r_state)
            cds_pkg::S_CLEAR: begin
                fifo_we   = 1'b1;
                cst_we    = 1'b1;
                cst_waddr = AW'(r_sweep);
            end
            cds_pkg::S_APPLY: begin
                cst_we = 1'b1;
                if (rep_ok) begin
                    cst_wdata = {1'b1, cs_att};
                end else begin
                    cst_wdata  = {cs_done, att_inc};
                    fifo_waddr = AW'(tail);
                    fifo_wdata = r_chunk_sel;
                    fifo_we    = !att_fatal && (32'(r_count) < MAX_CHUNKS);
                end
            end
            default: begin
                fifo_we = 1'b0;
            end
        endcase
    end

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_total   <= cds_pkg::CTW'(1);
            r_chunk_bytes   <= cds_pkg::CBW'(1048576);
            r_file_bytes    <= cds_pkg::FBW'(1);
            r_credit_limit  <= cds_pkg::CLW'(1);
            r_initial_peers <= cds_pkg::IPW'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cds_pkg::CFG_CHUNK_TOTAL:   r_chunk_total   <= i_cfg_data[cds_pkg::CTW-1:0];
                cds_pkg::CFG_CHUNK_BYTES:   r_chunk_bytes   <= i_cfg_data[cds_pkg::CBW-1:0];
                cds_pkg::CFG_FILE_BYTES:    r_file_bytes    <= i_cfg_data[cds_pkg::FBW-1:0];
                cds_pkg::CFG_CREDIT_LIMIT:  r_credit_limit  <= i_cfg_data[cds_pkg::CLW-1:0];
                cds_pkg::CFG_INITIAL_PEERS: r_initial_peers <= i_cfg_data[cds_pkg::IPW-1:0];
                default: ;
            endcase
        end
    end

    // Latch the item payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_chunk_sel  <= i_chunk_sel;
            r_peer_sel   <= i_peer_sel;
            r_outcome    <= i_outcome;
            r_byte_count <= i_byte_count;
        end
    end

    // Sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= cds_pkg::S_IDLE;
            r_halted     <= cds_pkg::H_RUN;
            r_n_chunks   <= '0;
            r_peer_count <= PCW'(1);
            r_head       <= '0;
            r_count      <= '0;
            r_rr         <= '0;
            r_completed  <= '0;
            r_active     <= '0;
            r_byte_total <= '0;
            r_delivered  <= '0;
            for (int i = 0; i < MAX_PEERS; i++) r_credit[i] <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                cds_pkg::S_IDLE: begin
                    if (in_fire) begin
                        r_res_status <= (i_func == cds_pkg::FN_ADD_PEER) ? cds_pkg::ST_PEER
                                                                         : cds_pkg::ST_NONE;
                        r_res_chunk  <= '0;
                        r_res_peer   <= '0;
                        r_off        <= '0;
                        r_res_len    <= '0;
                        r_scan_idx   <= r_rr;
                        r_scan_n     <= '0;
                        r_sweep      <= '0;
                        case (i_func)
                            cds_pkg::FN_START: begin
                                // Clear the run and latch the clamped sizes
                                r_halted     <= cds_pkg::H_RUN;
                                r_n_chunks   <= n_chunks_clamp;
                                r_peer_count <= peers_clamp;
                                r_head       <= '0;
                                r_count      <= '0;
                                r_rr         <= '0;
                                r_completed  <= '0;
                                r_active     <= '0;
                                r_byte_total <= '0;
                                r_delivered  <= '0;
                                for (int i = 0; i < MAX_PEERS; i++) r_credit[i] <= '0;
                            end
                            cds_pkg::FN_ADD_PEER: begin
                                if (32'(r_peer_count) < MAX_PEERS) begin
                                    r_peer_count <= r_peer_count + PCW'(1);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                cds_pkg::S_CLEAR: begin
                    // Sweep: refill the FIFO in order, clear chunk state
                    r_sweep <= r_sweep + CIW'(1);
                    if (32'(r_sweep) == MAX_CHUNKS - 1) r_count <= r_n_chunks;
                end
                cds_pkg::S_SCAN: begin
                    if (scan_hit) begin
                        // Grant: take a credit, advance pointer, pop the head
                        r_credit[r_scan_idx] <= r_credit[r_scan_idx] + cds_pkg::CLW'(1);
                        r_rr       <= scan_next;
                        r_res_peer <= r_scan_idx;
                        r_head     <= head_next;
                        r_count    <= r_count - CCW'(1);
                    end else begin
                        r_scan_idx <= scan_next;
                        r_scan_n   <= r_scan_n + PCW'(1);
                    end
                end
                cds_pkg::S_FETCH: begin
                    r_res_chunk <= fifo_rdata;
                    r_off       <= OW'(PW'(fifo_rdata) * PW'(r_chunk_bytes));
                end
                cds_pkg::S_CLIP: begin
                    r_res_status <= cds_pkg::ST_GRANTED;
                    if (r_off < OW'(r_file_bytes)) begin
                        r_res_len <= (len_wide > OW'(r_chunk_bytes)) ? r_chunk_bytes
                                                                     : cds_pkg::CBW'(len_wide);
                    end
                end
                cds_pkg::S_CHECK: begin
                    if (r_halted == cds_pkg::H_FINISHED) begin
                        r_res_status <= cds_pkg::ST_FINISHED;
                    end else if (r_halted == cds_pkg::H_FAILED) begin
                        r_res_status <= cds_pkg::ST_FAILED;
                    end else if (!rep_bad) begin
                        // Release the peer's credit
                        if (r_credit[r_peer_sel] != '0) begin
                            r_credit[r_peer_sel] <= r_credit[r_peer_sel] - cds_pkg::CLW'(1);
                        end
                        if (rep_wfail) begin
                            r_halted     <= cds_pkg::H_FAILED;
                            r_count      <= '0;
                            r_res_status <= cds_pkg::ST_FAILED;
                        end
                    end
                end
                cds_pkg::S_APPLY: begin
                    if (rep_ok) begin
                        r_byte_total <= byte_sum[cds_pkg::FBW] ? '1
                                                               : byte_sum[cds_pkg::FBW-1:0];
                        if (!r_delivered[r_peer_sel]) begin
                            r_delivered[r_peer_sel] <= 1'b1;
                            r_active <= r_active + PCW'(1);
                        end
                        r_completed <= completed_inc;
                        if (completed_inc >= r_n_chunks) begin
                            r_halted     <= cds_pkg::H_FINISHED;
                            r_count      <= '0;
                            r_res_status <= cds_pkg::ST_FINISHED;
                        end else begin
                            r_res_status <= cds_pkg::ST_ACCEPTED;
                        end
                    end else if (att_fatal) begin
                        r_halted     <= cds_pkg::H_FAILED;
                        r_count      <= '0;
                        r_res_status <= cds_pkg::ST_FAILED;
                    end else begin
                        // Requeue; drop when the FIFO is full
                        r_res_status <= cds_pkg::ST_REQUEUED;
                        if (32'(r_count) < MAX_CHUNKS) r_count <= r_count + CCW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == cds_pkg::S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == cds_pkg::S_OUT && out_free) begin
            r_o_status <= r_res_status;
            r_o_chunk  <= r_res_chunk;
            r_o_peer   <= r_res_peer;
            r_o_off    <= r_off[cds_pkg::FBW-1:0];
            r_o_len    <= r_res_len;
            r_o_done   <= r_completed;
            r_o_active <= r_active;
            r_o_bytes  <= r_byte_total;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_chunk_out    = r_o_chunk;
    assign o_peer_out     = r_o_peer;
    assign o_chunk_offset = r_o_off;
    assign o_chunk_length = r_o_len;
    assign o_done_count   = r_o_done;
    assign o_active_peers = r_o_active;
    assign o_bytes_done   = r_o_bytes;

endmodule
`default_nettype wire
